[src/spq_pkg.sv]
// Package for the strict-priority three-queue scheduler.
// Holds the status and class codes, the command control struct and default sizes.
// No dependencies.
package spq_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int QUEUE_DEPTH_DEF = 128;
  localparam int ID_WIDTH_DEF    = 16;

  // Depth of the command queue between the front and back parts.
  localparam int CMD_DEPTH = 4;

  // Fixed widths of the request and result fields.
  localparam int PORT_ID_W = 16;
  localparam int CLASS_W   = 2;
  localparam int STATUS_W  = 3;
  localparam int CLASS_COUNT = 3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DEQUEUED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd4;

  // Class codes, highest priority first.
  localparam logic [CLASS_W-1:0] CLS_EMERGENCY = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_PASSENGER = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_CARGO     = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN   = 2'd3;

  // Operation codes.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Control part of a command passed from the front part to the back part.
  typedef struct packed {
    logic                wr;
    logic                rd;
    logic [STATUS_W-1:0] status;
    logic [CLASS_W-1:0]  cls;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

endpackage

[src/spq_front.sv]
// Front part of the scheduler: classifies each request and keeps the queue bookkeeping.
// Owns the head, tail and fill count of every class. Depends on spq_pkg.
module spq_front #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = spq_pkg::ID_WIDTH_DEF,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            operation,
  input  logic [spq_pkg::CLASS_W-1:0]     item_class,
  input  logic [spq_pkg::PORT_ID_W-1:0]   item_id,
  output spq_pkg::ctl_t                   ctl,
  output logic [AW-1:0]                   addr,
  output logic [ID_WIDTH-1:0]             id
);

  logic [AW-1:0] head  [spq_pkg::CLASS_COUNT];
  logic [AW-1:0] tail  [spq_pkg::CLASS_COUNT];
  logic [CW-1:0] count [spq_pkg::CLASS_COUNT];

  logic [63:0]   id_ext;
  logic [CW-1:0] sel_count;
  logic [AW-1:0] sel_tail;
  logic          found;
  logic [spq_pkg::CLASS_W-1:0] deq_cls;
  logic [AW-1:0] deq_head;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // The identifier is kept to ID_WIDTH bits.
  assign id_ext = 64'(item_id);
  assign id     = id_ext[ID_WIDTH-1:0];

  // Pick the tail and count of the request's class, and the highest-priority busy queue.
  always_comb begin
    sel_count = '0;
    sel_tail  = '0;
    found     = 1'b0;
    deq_cls   = spq_pkg::CLS_EMERGENCY;
    deq_head  = '0;
    for (int c = 0; c < spq_pkg::CLASS_COUNT; c++) begin
      if (item_class == spq_pkg::CLASS_W'(c)) begin
        sel_count = count[c];
        sel_tail  = tail[c];
      end
      if (!found && count[c] != '0) begin
        found    = 1'b1;
        deq_cls  = spq_pkg::CLASS_W'(c);
        deq_head = head[c];
      end
    end
  end

  // Build the command for the back part.
  always_comb begin
    ctl.wr     = 1'b0;
    ctl.rd     = 1'b0;
    ctl.status = spq_pkg::ST_NONE;
    ctl.cls    = spq_pkg::CLS_EMERGENCY;
    addr       = '0;
    if (operation == spq_pkg::OP_ENQUEUE) begin
      if (item_class == spq_pkg::CLS_UNKNOWN) begin
        ctl.status = spq_pkg::ST_UNKNOWN;
        ctl.cls    = spq_pkg::CLS_UNKNOWN;
      end else if (sel_count == CW'(QUEUE_DEPTH)) begin
        ctl.status = spq_pkg::ST_DROPPED;
        ctl.cls    = item_class;
      end else begin
        ctl.status = spq_pkg::ST_ENQUEUED;
        ctl.cls    = item_class;
        ctl.wr     = 1'b1;
        addr       = sel_tail;
      end
    end else if (found) begin
      ctl.status = spq_pkg::ST_DEQUEUED;
      ctl.cls    = deq_cls;
      ctl.rd     = 1'b1;
      addr       = deq_head;
    end
  end

  // Advance the pointers and counts of the touched class.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < spq_pkg::CLASS_COUNT; c++) begin
        head[c]  <= '0;
        tail[c]  <= '0;
        count[c] <= '0;
      end
    end else if (accept) begin
      for (int c = 0; c < spq_pkg::CLASS_COUNT; c++) begin
        if (ctl.wr && ctl.cls == spq_pkg::CLASS_W'(c)) begin
          tail[c]  <= adv(tail[c]);
          count[c] <= count[c] + 1'b1;
        end
        if (ctl.rd && ctl.cls == spq_pkg::CLASS_W'(c)) begin
          head[c]  <= adv(head[c]);
          count[c] <= count[c] - 1'b1;
        end
      end
    end
  end

  // No queue ever holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count[0] <= CW'(QUEUE_DEPTH) && count[1] <= CW'(QUEUE_DEPTH) &&
    count[2] <= CW'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  // An accepted dequeue that finds an emergency item leaves one fewer behind.
  a_deq_emergency: assert property (@(posedge clk) disable iff (rst)
    accept && ctl.rd && ctl.cls == spq_pkg::CLS_EMERGENCY |=>
    count[0] == $past(count[0]) - 1'b1)
    else $error("emergency count not decremented on dequeue");

endmodule

[src/spq_cmd_fifo.sv]
// Short command queue between the front and back parts of the scheduler.
// Register-based circular buffer with a fill count. Depends on spq_pkg.
module spq_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = spq_pkg::CMD_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= adv(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= adv(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // The fill count stays within the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("command queue count above depth");

  // A lone push raises the count by one.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("command queue count not raised on push");

endmodule

[src/spq_back.sv]
// Back part of the scheduler: carries out commands against the three item stores.
// Holds the stores and the result register. Depends on spq_pkg.
module spq_back #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = spq_pkg::ID_WIDTH_DEF,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  spq_pkg::ctl_t                   cmd_ctl,
  input  logic [AW-1:0]                   cmd_addr,
  input  logic [ID_WIDTH-1:0]             cmd_id,
  output logic                            cmd_pop,
  output logic                            empty,
  input  logic                            pop,
  output logic [spq_pkg::STATUS_W-1:0]    status,
  output logic [spq_pkg::CLASS_W-1:0]     out_class,
  output logic [spq_pkg::PORT_ID_W-1:0]   out_id
);

  logic                          r_valid;
  logic                          r_rd;
  logic [spq_pkg::STATUS_W-1:0]  r_status;
  logic [spq_pkg::CLASS_W-1:0]   r_class;
  logic [ID_WIDTH-1:0]           sel_data;
  logic [63:0]                   sel_ext;

  // A command is taken when the result register is free or being drained.
  assign cmd_pop = cmd_valid && (!r_valid || pop);

  // One store per class, written and read with registered data.
  for (genvar g = 0; g < spq_pkg::CLASS_COUNT; g++) begin : g_store
    logic [ID_WIDTH-1:0] store [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] rd_q;

    always_ff @(posedge clk) begin
      if (cmd_pop && cmd_ctl.cls == spq_pkg::CLASS_W'(g)) begin
        if (cmd_ctl.wr) begin
          store[cmd_addr] <= cmd_id;
        end
        if (cmd_ctl.rd) begin
          rd_q <= store[cmd_addr];
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (cmd_pop) begin
      r_valid <= 1'b1;
    end else if (pop) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      r_rd     <= cmd_ctl.rd;
      r_status <= cmd_ctl.status;
      r_class  <= cmd_ctl.cls;
    end
  end

  // Select the read data of the dequeued class.
  always_comb begin
    case (r_class)
      spq_pkg::CLS_EMERGENCY: sel_data = g_store[0].rd_q;
      spq_pkg::CLS_PASSENGER: sel_data = g_store[1].rd_q;
      spq_pkg::CLS_CARGO:     sel_data = g_store[2].rd_q;
      default:                sel_data = '0;
    endcase
  end

  assign sel_ext   = 64'(sel_data);
  assign empty     = !r_valid;
  assign status    = r_status;
  assign out_class = r_class;
  assign out_id    = r_rd ? sel_ext[spq_pkg::PORT_ID_W-1:0] : '0;

  // Only a dequeue result carries store data.
  a_rd_status: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_rd |-> r_status == spq_pkg::ST_DEQUEUED)
    else $error("store read on a result that is not a dequeue");

  // A command is never taken while a waiting result is held back.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    r_valid && !pop |-> !cmd_pop)
    else $error("result overwritten before it was taken");

endmodule

[src/strict_priority_three_queue_scheduler_core.sv]
// Strict-priority scheduler over three FIFO queues (emergency, passenger, cargo).
// Accepted requests pass the command queue, then the store access and the result register.
// An untaken result stalls later commands; each request touches at most one store entry and
// one class's counts. Throughput: one request per cycle while the command queue is not full.
// Reset (rst, synchronous) empties all queues and the command queue; store contents are not cleared.
// Depends on spq_pkg, spq_front, spq_cmd_fifo and spq_back.
module strict_priority_three_queue_scheduler_core #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = spq_pkg::ID_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            operation,
  input  logic [spq_pkg::CLASS_W-1:0]     item_class,
  input  logic [spq_pkg::PORT_ID_W-1:0]   item_id,
  output logic                            empty,
  input  logic                            pop,
  output logic [spq_pkg::STATUS_W-1:0]    status,
  output logic [spq_pkg::CLASS_W-1:0]     out_class,
  output logic [spq_pkg::PORT_ID_W-1:0]   out_id
);

  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CMD_W = spq_pkg::CTL_W + AW + ID_WIDTH;

  logic                  accept;
  spq_pkg::ctl_t         f_ctl;
  logic [AW-1:0]         f_addr;
  logic [ID_WIDTH-1:0]   f_id;
  logic [CMD_W-1:0]      q_din;
  logic [CMD_W-1:0]      q_dout;
  logic                  q_empty;
  logic                  b_pop;

  assign accept = push && !full;

  // Front part: classify the request and update the queue bookkeeping.
  spq_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .item_class(item_class),
    .item_id   (item_id),
    .ctl       (f_ctl),
    .addr      (f_addr),
    .id        (f_id)
  );

  assign q_din = {f_ctl, f_addr, f_id};

  // Command queue between the two parts.
  spq_cmd_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(spq_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (q_din),
    .full (full),
    .pop  (b_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  // Back part: store access and result register.
  spq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(!q_empty),
    .cmd_ctl  (spq_pkg::ctl_t'(q_dout[CMD_W-1 -: spq_pkg::CTL_W])),
    .cmd_addr (q_dout[ID_WIDTH +: AW]),
    .cmd_id   (q_dout[ID_WIDTH-1:0]),
    .cmd_pop  (b_pop),
    .empty    (empty),
    .pop      (pop),
    .status   (status),
    .out_class(out_class),
    .out_id   (out_id)
  );

endmodule
